// ===== rtl/core/rc4_pkg.sv =====
// Shared constants and types for the RC4 stream cipher.
package rc4_pkg;

    localparam int KEY_DEPTH  = 256;
    localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KC_W       = $clog2(KEY_DEPTH + 1);
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    typedef logic [7:0]        t_byte;
    typedef logic [KC_W-1:0]   t_key_count;
    typedef logic [KEY_AW-1:0] t_key_addr;

    localparam t_byte      BYTE_MAX     = 8'hff;
    localparam t_key_count KEY_COUNT_MAX = t_key_count'(KEY_DEPTH);

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

endpackage

// ===== rtl/core/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-old on collision).
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rc4_stream_cipher.sv =====
// RC4 stream cipher top level: key store, permutation RAM, sequencer and output register.
//
// Usage:
//   Input channel (i_valid / o_ready) carries i_func, i_data_byte, i_last_key_byte.
//   A beat with i_func = key loads one key byte and produces no result.
//   The key beat marked with i_last_key_byte starts the key schedule: an identity
//   fill of the permutation RAM, then 256 steps through states KS_A to KS_D, and
//   the block accepts nothing until the schedule ends. Indices are then zero.
//   A beat with i_func = data produces one result beat on the output channel
//   (o_valid / i_ready, payload o_out_byte): the data byte XOR the keystream byte.
//   The result reaches the output register through states D_J, D_K and D_OUT;
//   a new data beat is accepted only once the last one is done. These steps come
//   from the single read port of the permutation RAM: read S[i], read S[j], then
//   read the keystream entry, with the two swap writes on the write port.
//   When the receiver stalls, the output register holds its beat while the next
//   input beat is already accepted and worked on; that beat then waits in its last
//   step until the register frees up.
//   Reset clears the indices, the key byte count and the output valid; the RAMs
//   are not cleared, so data must only be sent once a key has been loaded.
module rc4_stream_cipher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_key_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_D_J   = 4'd1;  // S[i] arrives, read S[j]
    localparam logic [3:0] ST_D_K   = 4'd2;  // S[j] arrives, write S[i], read keystream
    localparam logic [3:0] ST_D_OUT = 4'd3;  // write S[j], load output register
    localparam logic [3:0] ST_INIT  = 4'd4;  // identity fill
    localparam logic [3:0] ST_KS_A  = 4'd5;  // read S[n] and key[k]
    localparam logic [3:0] ST_KS_B  = 4'd6;  // compute j, read S[j]
    localparam logic [3:0] ST_KS_C  = 4'd7;  // write S[n] = S[j]
    localparam logic [3:0] ST_KS_D  = 4'd8;  // write S[j] = t

    logic [3:0]             r_state, n_state;
    rc4_pkg::t_byte         r_i, n_i;
    rc4_pkg::t_byte         r_j, n_j;
    rc4_pkg::t_key_count    r_key_count, n_key_count;
    rc4_pkg::t_key_count    r_len, n_len;
    rc4_pkg::t_key_addr     r_k, n_k;
    rc4_pkg::t_byte         r_n, n_n;
    rc4_pkg::t_byte         r_ti, n_ti;
    rc4_pkg::t_byte         r_tj, n_tj;
    rc4_pkg::t_byte         r_ks_addr, n_ks_addr;
    rc4_pkg::t_byte         r_byte, n_byte;
    logic                   r_out_valid, n_out_valid;
    rc4_pkg::t_byte         r_out_byte, n_out_byte;

    logic                   perm_we;
    rc4_pkg::t_byte         perm_waddr, perm_wdata, perm_raddr, perm_rdata;
    logic                   key_we;
    rc4_pkg::t_key_addr     key_waddr, key_raddr;
    rc4_pkg::t_byte         key_rdata;

    logic                   in_fire;
    rc4_pkg::t_key_count    count_sat;
    rc4_pkg::t_key_count    k_inc;
    rc4_pkg::t_byte         ks_byte;
    rc4_pkg::t_byte         ks_sum;

    rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::PERM_DEPTH)) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::KEY_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign in_fire    = i_valid && o_ready;
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

    // Saturate the key byte count; drop bytes past the key store depth.
    assign count_sat = (r_key_count < rc4_pkg::KEY_COUNT_MAX)
                       ? rc4_pkg::t_key_count'(r_key_count + 1'b1) : r_key_count;
    assign k_inc     = rc4_pkg::t_key_count'(rc4_pkg::t_key_count'(r_k) + 1'b1);
    assign ks_sum    = rc4_pkg::t_byte'(r_j + key_rdata + perm_rdata);

    // Forward the swap results over the keystream read: the RAM returns data from
    // before the S[i] write (and before the S[j] write), so patch both entries.
    always_comb begin
        if (r_ks_addr == r_j) begin
            ks_byte = r_ti;
        end else if (r_ks_addr == r_i) begin
            ks_byte = r_tj;
        end else begin
            ks_byte = perm_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_key_count = r_key_count;
        n_len       = r_len;
        n_k         = r_k;
        n_n         = r_n;
        n_ti        = r_ti;
        n_tj        = r_tj;
        n_ks_addr   = r_ks_addr;
        n_byte      = r_byte;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;

        perm_we    = 1'b0;
        perm_waddr = r_n;
        perm_wdata = r_n;
        perm_raddr = rc4_pkg::t_byte'(r_i + 1'b1);
        key_we     = 1'b0;
        key_waddr  = r_key_count[rc4_pkg::KEY_AW-1:0];
        key_raddr  = r_k;

        // Drain the output register.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // Read S[i+1] ahead of the next data beat.
                if (in_fire) begin
                    if (i_func == rc4_pkg::FUNC_DATA) begin
                        n_i     = rc4_pkg::t_byte'(r_i + 1'b1);
                        n_byte  = i_data_byte;
                        n_state = ST_D_J;
                    end else begin
                        key_we = (r_key_count < rc4_pkg::KEY_COUNT_MAX);
                        if (i_last_key_byte) begin
                            n_len       = count_sat;
                            n_key_count = '0;
                            n_n         = '0;
                            n_state     = ST_INIT;
                        end else begin
                            n_key_count = count_sat;
                        end
                    end
                end
            end
            ST_D_J: begin
                n_ti       = perm_rdata;
                n_j        = rc4_pkg::t_byte'(r_j + perm_rdata);
                perm_raddr = rc4_pkg::t_byte'(r_j + perm_rdata);
                n_state    = ST_D_K;
            end
            ST_D_K: begin
                n_tj       = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = perm_rdata;
                n_ks_addr  = rc4_pkg::t_byte'(r_ti + perm_rdata);
                perm_raddr = rc4_pkg::t_byte'(r_ti + perm_rdata);
                n_state    = ST_D_OUT;
            end
            ST_D_OUT: begin
                // Hold here while the output register is still full.
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_ti;
                perm_raddr = r_ks_addr;
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_byte ^ ks_byte;
                    n_state     = ST_IDLE;
                end
            end
            ST_INIT: begin
                perm_we = 1'b1;
                n_n     = rc4_pkg::t_byte'(r_n + 1'b1);
                if (r_n == rc4_pkg::BYTE_MAX) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_KS_A;
                end
            end
            ST_KS_A: begin
                perm_raddr = r_n;
                n_state    = ST_KS_B;
            end
            ST_KS_B: begin
                n_ti       = perm_rdata;
                n_j        = ks_sum;
                perm_raddr = ks_sum;
                if (k_inc >= r_len) begin
                    n_k = '0;
                end else begin
                    n_k = k_inc[rc4_pkg::KEY_AW-1:0];
                end
                n_state = ST_KS_C;
            end
            ST_KS_C: begin
                perm_we    = 1'b1;
                perm_waddr = r_n;
                perm_wdata = perm_rdata;
                n_state    = ST_KS_D;
            end
            ST_KS_D: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_ti;
                n_n        = rc4_pkg::t_byte'(r_n + 1'b1);
                if (r_n == rc4_pkg::BYTE_MAX) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_KS_A;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_key_count <= n_key_count;
            r_out_valid <= n_out_valid;
        end
        r_len      <= n_len;
        r_k        <= n_k;
        r_n        <= n_n;
        r_ti       <= n_ti;
        r_tj       <= n_tj;
        r_ks_addr  <= n_ks_addr;
        r_byte     <= n_byte;
        r_out_byte <= n_out_byte;
    end

    // Key byte count never passes the key store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= rc4_pkg::KEY_COUNT_MAX)
        else $error("key byte count past key store depth");

    // Key index stays inside the loaded key during the schedule.
    a_key_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_A || r_state == ST_KS_B || r_state == ST_KS_C ||
         r_state == ST_KS_D) |-> (rc4_pkg::t_key_count'(r_k) < r_len))
        else $error("key index outside loaded key");

    // Schedule end returns to idle with both indices cleared.
    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_D && r_n == rc4_pkg::BYTE_MAX)
        |=> (r_state == ST_IDLE && r_i == '0 && r_j == '0))
        else $error("indices not cleared after key schedule");

    // The permutation RAM is never written while the block waits for a beat.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !perm_we)
        else $error("permutation write while idle");

    // A finished result never overwrites a beat the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("output beat lost");

endmodule
